// ===== hw/rtl/kfc_pkg.sv =====
// Shared types, key codes, ASCII codes and helpers for the keypad calculator.
package kfc_pkg;

  localparam int unsigned OPERAND_BITS_DEF = 32;
  localparam int unsigned KEY_W            = 5;
  localparam int unsigned KIND_W           = 2;
  localparam int unsigned CHAR_W           = 7;
  localparam int unsigned MAG_W            = 32;
  localparam int unsigned HUND_W           = 7;
  localparam int unsigned DIGIT_W          = 4;
  localparam int unsigned FRAC_SCALE       = 100;

  // keypad scan codes
  localparam logic [KEY_W-1:0] KEY_D7     = 5'd1;
  localparam logic [KEY_W-1:0] KEY_D8     = 5'd2;
  localparam logic [KEY_W-1:0] KEY_D9     = 5'd3;
  localparam logic [KEY_W-1:0] KEY_DIV    = 5'd4;
  localparam logic [KEY_W-1:0] KEY_D4     = 5'd5;
  localparam logic [KEY_W-1:0] KEY_D5     = 5'd6;
  localparam logic [KEY_W-1:0] KEY_D6     = 5'd7;
  localparam logic [KEY_W-1:0] KEY_MUL    = 5'd8;
  localparam logic [KEY_W-1:0] KEY_D1     = 5'd9;
  localparam logic [KEY_W-1:0] KEY_D2     = 5'd10;
  localparam logic [KEY_W-1:0] KEY_D3     = 5'd11;
  localparam logic [KEY_W-1:0] KEY_SUB    = 5'd12;
  localparam logic [KEY_W-1:0] KEY_CLEAR  = 5'd13;
  localparam logic [KEY_W-1:0] KEY_D0     = 5'd14;
  localparam logic [KEY_W-1:0] KEY_EQUALS = 5'd15;
  localparam logic [KEY_W-1:0] KEY_ADD    = 5'd16;

  // ASCII
  localparam logic [CHAR_W-1:0] CHR_NUL  = 7'h00;
  localparam logic [CHAR_W-1:0] CHR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHR_DIV  = 7'h2F;
  localparam logic [CHAR_W-1:0] CHR_MUL  = 7'h2A;
  localparam logic [CHAR_W-1:0] CHR_SUB  = 7'h2D;
  localparam logic [CHAR_W-1:0] CHR_ADD  = 7'h2B;
  localparam logic [CHAR_W-1:0] CHR_EQ   = 7'h3D;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    EVT_ECHO    = 2'd0,
    EVT_RESULT  = 2'd1,
    EVT_DIVZERO = 2'd2,
    EVT_CLEARED = 2'd3
  } evt_t;

  typedef enum logic [2:0] {
    KC_NONE,
    KC_DIGIT,
    KC_OPER,
    KC_EQUALS,
    KC_CLEAR
  } key_class_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIG10,
    S_DIGADD,
    S_OPADD,
    S_EQADD,
    S_SUB1,
    S_SUB2,
    S_MUL,
    S_DIV,
    S_F5,
    S_F25,
    S_FDIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    key_class_t          cls;
    logic [DIGIT_W-1:0]  digit;
    op_t                 op;
    logic [CHAR_W-1:0]   ch;
  } key_info_t;

  function automatic key_info_t key_decode(input logic [KEY_W-1:0] key);
    key_info_t k;
    k.cls   = KC_DIGIT;
    k.digit = '0;
    k.op    = OP_ADD;
    k.ch    = CHR_NUL;
    case (key)
      KEY_D0:     k.digit = 4'd0;
      KEY_D1:     k.digit = 4'd1;
      KEY_D2:     k.digit = 4'd2;
      KEY_D3:     k.digit = 4'd3;
      KEY_D4:     k.digit = 4'd4;
      KEY_D5:     k.digit = 4'd5;
      KEY_D6:     k.digit = 4'd6;
      KEY_D7:     k.digit = 4'd7;
      KEY_D8:     k.digit = 4'd8;
      KEY_D9:     k.digit = 4'd9;
      KEY_DIV:    begin k.cls = KC_OPER; k.op = OP_DIV; k.ch = CHR_DIV; end
      KEY_MUL:    begin k.cls = KC_OPER; k.op = OP_MUL; k.ch = CHR_MUL; end
      KEY_SUB:    begin k.cls = KC_OPER; k.op = OP_SUB; k.ch = CHR_SUB; end
      KEY_ADD:    begin k.cls = KC_OPER; k.op = OP_ADD; k.ch = CHR_ADD; end
      KEY_EQUALS: begin k.cls = KC_EQUALS; k.ch = CHR_EQ; end
      KEY_CLEAR:  k.cls = KC_CLEAR;
      default:    k.cls = KC_NONE;
    endcase
    if (k.cls == KC_DIGIT) begin
      k.ch = CHR_ZERO + {3'b000, k.digit};
    end
    return k;
  endfunction

  // clamp an operand-width value (zero-extended to 64 bits) to the display width
  function automatic logic [MAG_W-1:0] sat_mag(input logic [63:0] v);
    logic [MAG_W-1:0] m;
    m = (v[63:MAG_W] != '0) ? '1 : v[MAG_W-1:0];
    return m;
  endfunction

endpackage

// ===== hw/rtl/kfc_if.sv =====
// Handshake interfaces for key codes in and calculator events out.
interface kfc_key_if;
  import kfc_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

interface kfc_evt_if;
  import kfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] event_kind;
  logic [CHAR_W-1:0] echo_char;
  logic [MAG_W-1:0]  magnitude;
  logic              is_negative;
  logic [HUND_W-1:0] hundredths;
  logic              has_fraction;

  modport source (output valid, output event_kind, output echo_char, output magnitude,
                  output is_negative, output hundredths, output has_fraction,
                  input ready);
  modport sink   (input valid, input event_kind, input echo_char, input magnitude,
                  input is_negative, input hundredths, input has_fraction,
                  output ready);
endinterface

// ===== hw/rtl/keypad_four_function_calculator.sv =====
// From key transfer to result register: a digit key goes S_DIG10, S_DIGADD; an operator
// S_OPADD; equals S_EQADD, S_SUB1 then S_SUB2 on a borrow, S_MUL, or S_DIV, S_F5, S_F25,
// S_FDIV by operator; clear and divide by zero go straight to S_EMIT. Keys are taken only
// in S_IDLE. Multiply and divide iterate one bit per cycle through a shared (N+7)-bit adder.
// A new key is taken while the previous result still waits in the output register.
// Synchronous active-low reset: operands zero, operator add, no result pending.
module keypad_four_function_calculator #(
  parameter int unsigned OPERAND_BITS = kfc_pkg::OPERAND_BITS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  kfc_key_if.sink    in_ch,
  kfc_evt_if.source  out_ch
);
  import kfc_pkg::*;

  localparam int unsigned N  = OPERAND_BITS;
  localparam int unsigned W  = N + 7;           // holds 100 * remainder
  localparam int unsigned CW = $clog2(N + 1);

  // architectural state
  logic [N-1:0] a_r, a_nxt;                     // first operand
  logic [N-1:0] b_r, b_nxt;                     // entry value
  op_t          op_r, op_nxt;

  // sequencer and work registers
  state_t             state_r, state_nxt;
  logic [W-1:0]       acc_r, acc_nxt;           // product / partial remainder
  logic [N-1:0]       q_r, q_nxt;               // multiplier or dividend/quotient shift
  logic [HUND_W-1:0]  h_r, h_nxt;               // fraction dividend/quotient shift
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [DIGIT_W-1:0] digit_r, digit_nxt;
  logic               eq_r, eq_nxt;             // current key was equals

  // result staged for the output register
  evt_t              res_kind_r, res_kind_nxt;
  logic [CHAR_W-1:0] res_char_r, res_char_nxt;
  logic [MAG_W-1:0]  res_mag_r, res_mag_nxt;
  logic              res_neg_r, res_neg_nxt;
  logic [HUND_W-1:0] res_hund_r, res_hund_nxt;
  logic              res_frac_r, res_frac_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  evt_t              out_kind_r;
  logic [CHAR_W-1:0] out_char_r;
  logic [MAG_W-1:0]  out_mag_r;
  logic              out_neg_r;
  logic [HUND_W-1:0] out_hund_r;
  logic              out_frac_r;

  logic      in_xfer, emit_go, last;
  key_info_t kinfo;

  // shared adder/subtractor
  logic [W-1:0] add_x, add_y;
  logic         add_sub;
  logic [W:0]   add_sum;
  logic         borrow, hi_ovf;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign kinfo       = key_decode(in_ch.key_code);
  assign emit_go     = (state_r == S_EMIT) && (!out_valid_r || out_ch.ready);
  assign last        = (cnt_r == CW'(1));

  assign add_sum = {1'b0, add_x} + ({1'b0, add_y} ^ {(W+1){add_sub}}) + (W+1)'(add_sub);
  assign borrow  = add_sum[W];
  assign hi_ovf  = |add_sum[W:N];

  // adder operand selection
  always_comb begin
    add_x   = '0;
    add_y   = '0;
    add_sub = 1'b0;
    case (state_r)
      S_DIG10: begin
        add_x = W'({b_r, 3'b000});
        add_y = W'({b_r, 1'b0});
      end
      S_DIGADD: begin
        add_x = acc_r;
        add_y = W'(digit_r);
      end
      S_OPADD, S_EQADD: begin
        add_x = W'(a_r);
        add_y = W'(b_r);
      end
      S_SUB1: begin
        add_x   = W'(a_r);
        add_y   = W'(b_r);
        add_sub = 1'b1;
      end
      S_SUB2: begin
        add_x   = W'(b_r);
        add_y   = W'(a_r);
        add_sub = 1'b1;
      end
      S_MUL: begin
        // MSB-first shift-and-add: 2P + bit*a
        add_x = W'({acc_r[N-2:0], 1'b0});
        add_y = q_r[N-1] ? W'(a_r) : '0;
      end
      S_DIV: begin
        add_x   = W'({acc_r[N-1:0], q_r[N-1]});
        add_y   = W'(b_r);
        add_sub = 1'b1;
      end
      S_F5: begin
        add_x = W'({acc_r[N-1:0], 2'b00});
        add_y = acc_r;
      end
      S_F25: begin
        add_x = W'({acc_r[N+2:0], 2'b00});
        add_y = acc_r;
      end
      S_FDIV: begin
        add_x   = W'({acc_r[N-1:0], h_r[HUND_W-1]});
        add_y   = W'(b_r);
        add_sub = 1'b1;
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          case (kinfo.cls)
            KC_DIGIT:  state_nxt = S_DIG10;
            KC_OPER:   state_nxt = S_OPADD;
            KC_CLEAR:  state_nxt = S_EMIT;
            KC_EQUALS: begin
              case (op_r)
                OP_ADD:  state_nxt = S_EQADD;
                OP_SUB:  state_nxt = S_SUB1;
                OP_MUL:  state_nxt = S_MUL;
                OP_DIV:  state_nxt = (b_r == '0) ? S_EMIT : S_DIV;
                default: state_nxt = S_EQADD;
              endcase
            end
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_DIG10:  state_nxt = S_DIGADD;
      S_DIGADD: state_nxt = S_EMIT;
      S_OPADD:  state_nxt = S_EMIT;
      S_EQADD:  state_nxt = S_EMIT;
      S_SUB1:   state_nxt = borrow ? S_SUB2 : S_EMIT;
      S_SUB2:   state_nxt = S_EMIT;
      S_MUL:    state_nxt = last ? S_EMIT : S_MUL;
      S_DIV:    state_nxt = last ? S_F5 : S_DIV;
      S_F5:     state_nxt = S_F25;
      S_F25:    state_nxt = S_FDIV;
      S_FDIV:   state_nxt = last ? S_EMIT : S_FDIV;
      S_EMIT:   state_nxt = emit_go ? S_IDLE : S_EMIT;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // datapath and result staging
  always_comb begin
    logic mul_ovf;
    a_nxt        = a_r;
    b_nxt        = b_r;
    op_nxt       = op_r;
    acc_nxt      = acc_r;
    q_nxt        = q_r;
    h_nxt        = h_r;
    cnt_nxt      = cnt_r;
    ovf_nxt      = ovf_r;
    digit_nxt    = digit_r;
    eq_nxt       = eq_r;
    res_kind_nxt = res_kind_r;
    res_char_nxt = res_char_r;
    res_mag_nxt  = res_mag_r;
    res_neg_nxt  = res_neg_r;
    res_hund_nxt = res_hund_r;
    res_frac_nxt = res_frac_r;
    mul_ovf      = ovf_r | acc_r[N-1] | hi_ovf;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          eq_nxt       = (kinfo.cls == KC_EQUALS);
          digit_nxt    = kinfo.digit;
          res_kind_nxt = EVT_ECHO;
          res_char_nxt = kinfo.ch;
          res_mag_nxt  = '0;
          res_neg_nxt  = 1'b0;
          res_hund_nxt = '0;
          res_frac_nxt = 1'b0;
          case (kinfo.cls)
            KC_OPER:  op_nxt = kinfo.op;
            KC_CLEAR: begin
              a_nxt        = '0;
              b_nxt        = '0;
              op_nxt       = OP_ADD;
              res_kind_nxt = EVT_CLEARED;
            end
            KC_EQUALS: begin
              res_kind_nxt = (op_r == OP_DIV && b_r == '0) ? EVT_DIVZERO : EVT_RESULT;
              acc_nxt      = '0;
              ovf_nxt      = 1'b0;
              cnt_nxt      = CW'(N);
              q_nxt        = (op_r == OP_DIV) ? a_r : b_r;
            end
            default: begin
              acc_nxt = acc_r;
            end
          endcase
        end
      end
      S_DIG10: acc_nxt = add_sum[W-1:0];
      S_DIGADD: b_nxt = hi_ovf ? '1 : add_sum[N-1:0];
      S_OPADD: begin
        a_nxt = hi_ovf ? '1 : add_sum[N-1:0];
        b_nxt = '0;
      end
      S_EQADD: res_mag_nxt = sat_mag(64'(hi_ovf ? {N{1'b1}} : add_sum[N-1:0]));
      S_SUB1: res_mag_nxt = sat_mag(64'(add_sum[N-1:0]));
      S_SUB2: begin
        res_mag_nxt = sat_mag(64'(add_sum[N-1:0]));
        res_neg_nxt = 1'b1;
      end
      S_MUL: begin
        ovf_nxt = mul_ovf;
        acc_nxt = W'(add_sum[N-1:0]);
        q_nxt   = {q_r[N-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
        if (last) begin
          res_mag_nxt = sat_mag(64'(mul_ovf ? {N{1'b1}} : add_sum[N-1:0]));
        end
      end
      S_DIV: begin
        // restoring step: keep the difference when it did not go negative
        acc_nxt = borrow ? W'({acc_r[N-2:0], q_r[N-1]}) : W'(add_sum[N-1:0]);
        q_nxt   = {q_r[N-2:0], ~borrow};
        cnt_nxt = cnt_r - CW'(1);
        if (last) begin
          res_mag_nxt = sat_mag(64'({q_r[N-2:0], ~borrow}));
        end
      end
      S_F5: acc_nxt = add_sum[W-1:0];
      S_F25: begin
        // 100r = 25r << 2; start the 7-bit long division with 100r >> 7
        acc_nxt = W'(add_sum[N+4:5]);
        h_nxt   = {add_sum[4:0], 2'b00};
        cnt_nxt = CW'(HUND_W);
      end
      S_FDIV: begin
        acc_nxt = borrow ? W'({acc_r[N-2:0], h_r[HUND_W-1]}) : W'(add_sum[N-1:0]);
        h_nxt   = {h_r[HUND_W-2:0], ~borrow};
        cnt_nxt = cnt_r - CW'(1);
        if (last) begin
          res_hund_nxt = {h_r[HUND_W-2:0], ~borrow};
          res_frac_nxt = 1'b1;
        end
      end
      S_EMIT: begin
        if (eq_r) begin
          a_nxt = '0;
          b_nxt = '0;
        end
      end
      default: begin
        acc_nxt = acc_r;
      end
    endcase
  end

  assign out_valid_nxt = emit_go ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      a_r         <= '0;
      b_r         <= '0;
      op_r        <= OP_ADD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      eq_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      a_r         <= a_nxt;
      b_r         <= b_nxt;
      op_r        <= op_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      eq_r        <= eq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    q_r        <= q_nxt;
    h_r        <= h_nxt;
    digit_r    <= digit_nxt;
    res_kind_r <= res_kind_nxt;
    res_char_r <= res_char_nxt;
    res_mag_r  <= res_mag_nxt;
    res_neg_r  <= res_neg_nxt;
    res_hund_r <= res_hund_nxt;
    res_frac_r <= res_frac_nxt;
    if (emit_go) begin
      out_kind_r <= res_kind_r;
      out_char_r <= res_char_r;
      out_mag_r  <= res_mag_r;
      out_neg_r  <= res_neg_r;
      out_hund_r <= res_hund_r;
      out_frac_r <= res_frac_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.event_kind   = out_kind_r;
  assign out_ch.echo_char    = out_char_r;
  assign out_ch.magnitude    = out_mag_r;
  assign out_ch.is_negative  = out_neg_r;
  assign out_ch.hundredths   = out_hund_r;
  assign out_ch.has_fraction = out_frac_r;

  // equals always leaves both operands cleared
  a_eq_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && eq_r) |=> (a_r == '0 && b_r == '0))
    else $error("operands not cleared after equals");

  // the divide loop is never entered with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_FDIV) |-> (b_r != '0))
    else $error("divide running with zero divisor");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(N))
    else $error("iteration counter out of range");

  // a fraction only ever comes with a result and stays below one
  a_frac_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frac_r) |->
      (out_kind_r == EVT_RESULT && out_hund_r < HUND_W'(FRAC_SCALE) && !out_neg_r))
    else $error("bad fractional result");

  a_neg_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_neg_r) |-> (out_kind_r == EVT_RESULT))
    else $error("sign flag on a non-result event");

endmodule
